>>> hw/rtl/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, constants and helpers of the SD card SPI-mode decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

  localparam int unsigned MaxBlockLen = 4096;
  localparam int unsigned SampleBits  = 48;
  localparam int unsigned SpanW       = 48;

  localparam logic [SpanW-1:0] SpanMask = (SampleBits >= SpanW) ? {SpanW{1'b1}} :
      SpanW'((64'd1 << SampleBits) - 64'd1);

  localparam logic [5:0] CmdGoIdle   = 6'd0;
  localparam logic [5:0] CmdOpCond   = 6'd1;
  localparam logic [5:0] CmdSendCsd  = 6'd9;
  localparam logic [5:0] CmdSendCid  = 6'd10;
  localparam logic [5:0] CmdBlockLen = 6'd16;
  localparam logic [5:0] CmdRead     = 6'd17;
  localparam logic [5:0] CmdWrite    = 6'd24;
  localparam logic [5:0] CmdSilent   = 6'd49;
  localparam logic [5:0] CmdAppCmd   = 6'd55;
  localparam logic [5:0] CmdCrcOnOff = 6'd59;

  localparam logic [7:0] DrAccepted = 8'h05;
  localparam logic [7:0] DrCrcRej   = 8'h0b;
  localparam logic [7:0] DrWrRej    = 8'h0d;

  localparam logic [3:0] EvKnownCmd = 4'd0;
  localparam logic [3:0] EvRawCmd   = 4'd1;
  localparam logic [3:0] EvR1       = 4'd2;
  localparam logic [3:0] EvRdStart  = 4'd3;
  localparam logic [3:0] EvRdData   = 4'd4;
  localparam logic [3:0] EvRdCrc    = 4'd5;
  localparam logic [3:0] EvWrStart  = 4'd6;
  localparam logic [3:0] EvWrData   = 4'd7;
  localparam logic [3:0] EvAccepted = 4'd8;
  localparam logic [3:0] EvCrcRej   = 4'd9;
  localparam logic [3:0] EvWrRej    = 4'd10;
  localparam logic [3:0] EvDataResp = 4'd11;
  localparam logic [3:0] EvBusy     = 4'd12;
  localparam logic [3:0] EvCsd      = 4'd13;
  localparam logic [3:0] EvCid      = 4'd14;

  localparam logic [7:0] ClsR1  = 8'd128;
  localparam logic [7:0] ClsBit = 8'd133;

  typedef struct packed {
    logic [3:0]       event_kind;
    logic [7:0]       ann_class;
    logic [5:0]       command_index;
    logic             app_command;
    logic [31:0]      argument;
    logic [7:0]       token_crc;
    logic [7:0]       status_byte;
    logic [SpanW-1:0] span_start;
    logic [SpanW-1:0] span_end;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0]     n;
    res_t [1:0]     res;
  } push_t;

  function automatic res_t mk_res(logic [3:0] kind, logic [7:0] cls, logic [7:0] status,
                                  logic [SpanW-1:0] s0, logic [SpanW-1:0] s1);
    res_t r;
    r             = '0;
    r.event_kind  = kind;
    r.ann_class   = cls;
    r.status_byte = status;
    r.span_start  = s0;
    r.span_end    = s1;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sdspi_decode.sv
// ----------------------------------------------------------------------------
// sdspi_decode
// Front end: parses one sniffed byte pair per cycle while accept_i is high and pushes results.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_decode #(
  parameter int unsigned MaxBlockLen = sdspi_pkg::MaxBlockLen,
  parameter int unsigned SampleBits  = sdspi_pkg::SampleBits
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic                        mode_i,
  input  wire logic                        mosi_valid_i,
  input  wire logic [7:0]                  mosi_byte_i,
  input  wire logic                        miso_valid_i,
  input  wire logic [7:0]                  miso_byte_i,
  input  wire logic [sdspi_pkg::SpanW-1:0] first_smp_i,
  input  wire logic [sdspi_pkg::SpanW-1:0] last_smp_i,
  output sdspi_pkg::push_t                 push_o
);

  localparam logic [3:0] PhIdle  = 4'd0;
  localparam logic [3:0] PhToken = 4'd1;
  localparam logic [3:0] PhCsd   = 4'd2;
  localparam logic [3:0] PhCid   = 4'd3;
  localparam logic [3:0] PhSkip  = 4'd4;
  localparam logic [3:0] PhR1    = 4'd5;
  localparam logic [3:0] PhRd    = 4'd6;
  localparam logic [3:0] PhWr    = 4'd7;
  localparam logic [3:0] PhDresp = 4'd8;
  localparam logic [3:0] PhBusy  = 4'd9;

  localparam int unsigned W = sdspi_pkg::SpanW;
  localparam int unsigned C = $clog2(MaxBlockLen + 4);
  localparam logic [C-1:0] CntSat = C'(MaxBlockLen + 3);
  localparam logic [C-1:0] MaxLen = C'(MaxBlockLen);
  localparam logic [C-1:0] DefLen = (MaxBlockLen < 512) ? MaxLen : C'(512);
  localparam logic [W-1:0] SMask  = (SampleBits >= W) ? {W{1'b1}} :
      W'((64'd1 << SampleBits) - 64'd1);

  logic [3:0]   phase_q, phase_d;
  logic [2:0]   tcnt_q, tcnt_d;
  logic [7:0]   tb_q [6];
  logic [7:0]   tb_d [6];
  logic         app_q, app_d, rdp_q, rdp_d, wrp_q, wrp_d;
  logic         rss_q, rss_d, wss_q, wss_d, bf_q, bf_d;
  logic [C-1:0] bc_q, bc_d, bl_q, bl_d;
  logic [W-1:0] cspan_q, cspan_d, dspan_q, dspan_d, crcs_q, crcs_d;
  logic [W-1:0] bss_q, bss_d, bse_q, bse_d;

  logic [7:0]     mosi, miso, m5;
  logic [W-1:0]   ss, es;
  logic [2:0]     cnt;
  logic [5:0]     cmd;
  logic [31:0]    arg;
  logic [C-1:0]   bl_eff, bc_inc;
  logic [C:0]     bl_w, bc_w;
  sdspi_pkg::res_t r0, r1;
  logic [1:0]     n;

  always_comb begin
    mosi   = mosi_valid_i ? mosi_byte_i : 8'h00;
    miso   = miso_valid_i ? miso_byte_i : 8'h00;
    m5     = miso & 8'h1f;
    ss     = first_smp_i & SMask;
    es     = last_smp_i & SMask;
    bc_inc = (bc_q < CntSat) ? bc_q + C'(1) : bc_q;
    bl_eff = (bc_q == '0 && bl_q == '0) ? DefLen : bl_q;
    bl_w   = {1'b0, bl_eff};
    bc_w   = {1'b0, bc_inc};
    cnt    = '0;
    cmd    = '0;
    arg    = '0;
    phase_d = phase_q; tcnt_d = tcnt_q; tb_d = tb_q;
    app_d = app_q; rdp_d = rdp_q; wrp_d = wrp_q; rss_d = rss_q; wss_d = wss_q;
    bf_d = bf_q; bc_d = bc_q; bl_d = bl_q;
    cspan_d = cspan_q; dspan_d = dspan_q; crcs_d = crcs_q; bss_d = bss_q; bse_d = bse_q;
    r0 = '0; r1 = '0; n = 2'd0;

    if (mode_i) begin
      phase_d = PhIdle; tcnt_d = '0;
      rdp_d = 1'b0; wrp_d = 1'b0; rss_d = 1'b0; wss_d = 1'b0;
    end else if ((phase_q == PhIdle && mosi != 8'hff) || phase_q == PhToken) begin
      cnt = (phase_q == PhIdle) ? 3'd0 : tcnt_q;
      phase_d = PhToken;
      if (cnt == 3'd0) cspan_d = ss;
      tb_d[cnt] = mosi;
      if (cnt < 3'd5) begin
        tcnt_d = cnt + 3'd1;
      end else begin
        tcnt_d = '0;
        cmd = tb_q[0][5:0];
        arg = {tb_q[1], tb_q[2], tb_q[3], tb_q[4]};
        phase_d = PhR1;
        if (cmd != sdspi_pkg::CmdSilent) begin
          if (cmd inside {sdspi_pkg::CmdGoIdle, sdspi_pkg::CmdOpCond, sdspi_pkg::CmdSendCsd,
                          sdspi_pkg::CmdSendCid, sdspi_pkg::CmdBlockLen, sdspi_pkg::CmdRead,
                          sdspi_pkg::CmdWrite, sdspi_pkg::CmdAppCmd,
                          sdspi_pkg::CmdCrcOnOff}) begin
            r0 = sdspi_pkg::mk_res(sdspi_pkg::EvKnownCmd, {2'b00, cmd}, 8'h00, cspan_q, es);
          end else begin
            r0 = sdspi_pkg::mk_res(sdspi_pkg::EvRawCmd, {1'b0, app_q, cmd}, 8'h00,
                                   cspan_q, es);
          end
          r0.command_index = cmd;
          r0.app_command   = app_q;
          r0.argument      = arg;
          r0.token_crc     = mosi;
          n = 2'd1;
          case (cmd)
            sdspi_pkg::CmdGoIdle, sdspi_pkg::CmdOpCond, sdspi_pkg::CmdCrcOnOff: ;
            sdspi_pkg::CmdSendCsd: begin bc_d = '0; phase_d = PhCsd; end
            sdspi_pkg::CmdSendCid: begin bc_d = '0; phase_d = PhCid; end
            sdspi_pkg::CmdBlockLen: bl_d = (arg > 32'(MaxBlockLen)) ? MaxLen : arg[C-1:0];
            sdspi_pkg::CmdRead: begin rdp_d = 1'b1; rss_d = 1'b0; bc_d = '0; end
            sdspi_pkg::CmdWrite: begin wrp_d = 1'b1; wss_d = 1'b0; bc_d = '0; end
            sdspi_pkg::CmdAppCmd: app_d = 1'b1;
            default: phase_d = PhSkip;
          endcase
        end
      end
    end else begin
      case (phase_q)
        PhIdle: ;
        PhCsd: begin
          if (bc_q == '0) cspan_d = ss;
          bc_d = bc_inc;
          if (bc_inc >= C'(20)) begin
            r0 = sdspi_pkg::mk_res(sdspi_pkg::EvCsd, {2'b00, sdspi_pkg::CmdSendCsd}, 8'h00,
                                   (bc_q == '0) ? ss : cspan_q, es);
            n = 2'd1; bc_d = '0; phase_d = PhIdle;
          end
        end
        PhCid: begin
          bc_d = bc_inc;
          if (bc_inc >= C'(16)) begin
            r0 = sdspi_pkg::mk_res(sdspi_pkg::EvCid, {2'b00, sdspi_pkg::CmdSendCid}, 8'h00,
                                   cspan_q, es);
            n = 2'd1; bc_d = '0; phase_d = PhR1;
          end
        end
        PhSkip: phase_d = PhR1;
        PhR1: begin
          if (miso != 8'hff) begin
            r0 = sdspi_pkg::mk_res(sdspi_pkg::EvR1, sdspi_pkg::ClsR1, miso, ss, es);
            n = 2'd1;
            phase_d = rdp_q ? PhRd : (wrp_q ? PhWr : PhIdle);
            if (tb_q[0][5:0] != sdspi_pkg::CmdAppCmd) app_d = 1'b0;
          end
        end
        PhRd: begin
          if (rss_q) begin
            if (bc_q == '0) begin dspan_d = ss; bl_d = bl_eff; end
            bc_d = bc_inc;
            if (bc_w == bl_w) begin
              r0 = sdspi_pkg::mk_res(sdspi_pkg::EvRdData, {2'b00, sdspi_pkg::CmdRead}, 8'h00,
                                     (bc_q == '0) ? ss : dspan_q, es);
              n = 2'd1;
            end else if (bc_w == bl_w + (C+1)'(1)) begin
              crcs_d = ss;
            end else if (bc_w == bl_w + (C+1)'(2)) begin
              r0 = sdspi_pkg::mk_res(sdspi_pkg::EvRdCrc, {2'b00, sdspi_pkg::CmdRead}, 8'h00,
                                     crcs_q, es);
              n = 2'd1; phase_d = PhIdle;
            end
          end else if (miso == 8'hfe) begin
            r0 = sdspi_pkg::mk_res(sdspi_pkg::EvRdStart, {2'b00, sdspi_pkg::CmdRead}, 8'h00,
                                   ss, es);
            n = 2'd1; rss_d = 1'b1; bc_d = '0;
          end
        end
        PhWr: begin
          if (wss_q) begin
            if (bc_q == '0) begin dspan_d = ss; bl_d = bl_eff; end
            bc_d = bc_inc;
            if (bc_w >= bl_w) begin
              r0 = sdspi_pkg::mk_res(sdspi_pkg::EvWrData, {2'b00, sdspi_pkg::CmdWrite}, 8'h00,
                                     (bc_q == '0) ? ss : dspan_q, es);
              n = 2'd1; bc_d = '0; phase_d = PhDresp;
            end
          end else if (mosi == 8'hfe) begin
            r0 = sdspi_pkg::mk_res(sdspi_pkg::EvWrStart, {2'b00, sdspi_pkg::CmdWrite}, 8'h00,
                                   ss, es);
            n = 2'd1; wss_d = 1'b1; bc_d = '0;
          end
        end
        PhDresp: begin
          if ((m5 & 8'h11) == 8'h01) begin
            if (m5 == sdspi_pkg::DrAccepted || m5 == sdspi_pkg::DrCrcRej ||
                m5 == sdspi_pkg::DrWrRej) begin
              r0 = sdspi_pkg::mk_res((m5 == sdspi_pkg::DrAccepted) ? sdspi_pkg::EvAccepted :
                                     (m5 == sdspi_pkg::DrCrcRej) ? sdspi_pkg::EvCrcRej :
                                     sdspi_pkg::EvWrRej, sdspi_pkg::ClsBit, m5, ss, es);
              n = 2'd1;
            end
            if (wrp_q) begin
              if (n == 2'd1) begin
                r1 = sdspi_pkg::mk_res(sdspi_pkg::EvDataResp, {2'b00, sdspi_pkg::CmdWrite},
                                       m5, ss, es);
                n  = 2'd2;
              end else begin
                r0 = sdspi_pkg::mk_res(sdspi_pkg::EvDataResp, {2'b00, sdspi_pkg::CmdWrite},
                                       m5, ss, es);
                n  = 2'd1;
              end
              phase_d = PhBusy; bf_d = 1'b1;
            end else begin
              phase_d = PhIdle;
            end
          end
        end
        PhBusy: begin
          if (miso != 8'h00) begin
            if (wrp_q) begin
              r0 = sdspi_pkg::mk_res(sdspi_pkg::EvBusy, {2'b00, sdspi_pkg::CmdWrite}, 8'h00,
                                     bss_q, bse_q);
              n = 2'd1;
            end
            phase_d = PhIdle;
          end else if (bf_q) begin
            bss_d = ss; bf_d = 1'b0;
          end else begin
            bse_d = es;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
    if (n == 2'd2) r1.last = 1'b1;
    else           r0.last = 1'b1;
  end

  assign push_o.n      = accept_i ? n : 2'd0;
  assign push_o.res[0] = r0;
  assign push_o.res[1] = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; tcnt_q <= '0; app_q <= 1'b0; rdp_q <= 1'b0; wrp_q <= 1'b0;
      rss_q <= 1'b0; wss_q <= 1'b0; bf_q <= 1'b0; bc_q <= '0; bl_q <= '0;
      cspan_q <= '0; dspan_q <= '0; crcs_q <= '0; bss_q <= '0; bse_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d; tcnt_q <= tcnt_d; app_q <= app_d; rdp_q <= rdp_d;
      wrp_q <= wrp_d; rss_q <= rss_d; wss_q <= wss_d; bf_q <= bf_d;
      bc_q <= bc_d; bl_q <= bl_d; cspan_q <= cspan_d; dspan_q <= dspan_d;
      crcs_q <= crcs_d; bss_q <= bss_d; bse_q <= bse_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) tb_q <= tb_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/sdspi_queue.sv
// ----------------------------------------------------------------------------
// sdspi_queue
// Back end: result queue taking up to two results per cycle, one out.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sdspi_pkg::push_t push_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output sdspi_pkg::res_t       res_o
);

  localparam int unsigned Depth = 8;
  localparam int unsigned AW    = $clog2(Depth);

  sdspi_pkg::res_t mem_q [Depth];
  logic [AW-1:0]   wptr_q, rptr_q;
  logic [AW:0]     cnt_q;
  logic            pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign room_o  = cnt_q <= (AW+1)'(Depth - 2);
  assign res_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wptr_q] <= push_i.res[0];
    if (push_i.n == 2'd2) mem_q[wptr_q + AW'(1)] <= push_i.res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + AW'(push_i.n);
      if (pop) rptr_q <= rptr_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i.n) - (AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sd_spi_protocol_decoder.sv
// ----------------------------------------------------------------------------
// sd_spi_protocol_decoder
// SD card SPI-mode decoder: sniffed byte pairs in, annotation events out.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                 tuser       tlast
// s_axis   in   spi byte pair and sample span         mode        -
// m_axis   out  decoded fields and annotated span     event_kind  last of item
//
// One byte pair per cycle while s_axis_tready is high; the parser state is registered.
// An item makes zero to two results, pushed into an eight-entry queue.
// Results are registered in the queue and reach m_axis in order, behind older results.
// s_axis_tready drops while fewer than two queue entries are free.
// Reset is asynchronous active low and clears the parse state and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_spi_protocol_decoder #(
  parameter int unsigned MaxBlockLen = sdspi_pkg::MaxBlockLen,
  parameter int unsigned SampleBits  = sdspi_pkg::SampleBits
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // mosi_valid, mosi_byte, miso_valid, miso_byte, first_sample, last_sample
  input  wire logic [119:0] s_axis_tdata,
  // mode
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // ann_class, command_index, app_command, argument, token_crc, status_byte,
  // span_start, span_end
  output logic [159:0]      m_axis_tdata,
  // event_kind
  output logic [3:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  sdspi_pkg::push_t push;
  sdspi_pkg::res_t  res;
  logic             room, accept;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  sdspi_decode #(
    .MaxBlockLen (MaxBlockLen),
    .SampleBits  (SampleBits)
  ) u_decode (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .mode_i         (s_axis_tuser[0]),
    .mosi_valid_i   (s_axis_tdata[0]),
    .mosi_byte_i    (s_axis_tdata[8:1]),
    .miso_valid_i   (s_axis_tdata[9]),
    .miso_byte_i    (s_axis_tdata[17:10]),
    .first_smp_i    (s_axis_tdata[65:18]),
    .last_smp_i     (s_axis_tdata[113:66]),
    .push_o         (push)
  );

  sdspi_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {1'b0, res.span_end, res.span_start, res.status_byte, res.token_crc,
                         res.argument, res.app_command, res.command_index, res.ann_class};
  assign m_axis_tuser = res.event_kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the SD card SPI-mode decoder. A cycle-level model
// built into the bench predicts the annotation events for every accepted byte
// pair. A checker compares each output transaction field by field with the
// oldest prediction. Stimulus is directed command flows followed by random
// well-formed flows mixed with noise, under several idle and stall profiles
// and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sdspi_pkg::*;

  localparam logic [7:0] StartToken  = 8'hfe;
  localparam logic [7:0] IdleByte    = 8'hff;
  localparam int unsigned CntSat     = MaxBlockLen + 3;
  localparam int unsigned CycleLimit = 100000;

  typedef enum logic [3:0] {
    PhIdle, PhToken, PhCsd, PhCid, PhSkip, PhR1, PhRd, PhWr, PhDresp, PhBusy
  } phase_e;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         m_axis_tlast;

  sd_spi_protocol_decoder u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  res_t        event_q[$];
  res_t        step_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          tx_idle = 0;
  int          rx_idle = 0;
  int          hold_cycles = 0;
  int          sent_items = 0;
  logic [47:0] sample_pos = 48'd100;

  phase_e      ph;
  logic [2:0]  tok_cnt;
  logic [7:0]  tok [6];
  logic        app_pfx, rd_pend, wr_pend, rd_start, wr_start, busy_first;
  logic [12:0] byte_cnt, blk_len;
  logic [47:0] cmd_s0, data_s0, crc_s0, busy_s0, busy_s1;

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial forever begin
    @(negedge clk_i);
    if (hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= rx_idle);
    end
  end

  function automatic void emit(logic [3:0] kind, logic [7:0] cls, logic [7:0] st,
                               logic [47:0] s0, logic [47:0] s1);
    step_q.push_back(mk_res(kind, cls, st, s0 & SpanMask, s1 & SpanMask));
  endfunction

  function automatic void bump_count();
    if (byte_cnt < CntSat) byte_cnt++;
  endfunction

  function automatic void take_token(logic [7:0] b, logic [47:0] ss, logic [47:0] es);
    logic [5:0]  cmd;
    logic [31:0] arg;
    bit          known;
    if (tok_cnt == 0) cmd_s0 = ss;
    tok[tok_cnt] = b;
    tok_cnt++;
    if (tok_cnt < 6) return;
    tok_cnt = 0;
    cmd = tok[0][5:0];
    arg = {tok[1], tok[2], tok[3], tok[4]};
    ph = PhR1;
    if (cmd == CmdSilent) return;
    known = cmd inside {CmdGoIdle, CmdOpCond, CmdSendCsd, CmdSendCid, CmdBlockLen,
                        CmdRead, CmdWrite, CmdAppCmd, CmdCrcOnOff};
    if (known) emit(EvKnownCmd, {2'b00, cmd}, 8'd0, cmd_s0, es);
    else emit(EvRawCmd, app_pfx ? 8'd64 + cmd : {2'b00, cmd}, 8'd0, cmd_s0, es);
    step_q[$].command_index = cmd;
    step_q[$].app_command = app_pfx;
    step_q[$].argument = arg;
    step_q[$].token_crc = tok[5];
    case (cmd)
      CmdGoIdle, CmdOpCond, CmdCrcOnOff: ;
      CmdSendCsd: begin byte_cnt = 0; ph = PhCsd; end
      CmdSendCid: begin byte_cnt = 0; ph = PhCid; end
      CmdBlockLen: blk_len = (arg > MaxBlockLen) ? 13'(MaxBlockLen) : arg[12:0];
      CmdRead: begin rd_pend = 1; rd_start = 0; byte_cnt = 0; end
      CmdWrite: begin wr_pend = 1; wr_start = 0; byte_cnt = 0; end
      CmdAppCmd: app_pfx = 1;
      default: ph = PhSkip;
    endcase
  endfunction

  function automatic void start_block(logic [47:0] ss);
    data_s0 = ss;
    if (blk_len == 0) blk_len = (MaxBlockLen < 512) ? 13'(MaxBlockLen) : 13'd512;
  endfunction

  task automatic predict_events(logic [119:0] d, logic md);
    logic [7:0]  mosi, miso, m;
    logic [47:0] ss, es;
    mosi = d[0] ? d[8:1] : 8'd0;
    miso = d[9] ? d[17:10] : 8'd0;
    ss = d[65:18] & SpanMask;
    es = d[113:66] & SpanMask;
    step_q.delete();
    if (md) begin
      ph = PhIdle; tok_cnt = 0;
      rd_pend = 0; wr_pend = 0; rd_start = 0; wr_start = 0;
      return;
    end
    case (ph)
      PhIdle: if (mosi != IdleByte) begin
        ph = PhToken; tok_cnt = 0; take_token(mosi, ss, es);
      end
      PhToken: take_token(mosi, ss, es);
      PhCsd: begin
        if (byte_cnt == 0) cmd_s0 = ss;
        bump_count();
        if (byte_cnt >= 20) begin
          emit(EvCsd, {2'b00, CmdSendCsd}, 8'd0, cmd_s0, es); byte_cnt = 0; ph = PhIdle;
        end
      end
      PhCid: begin
        bump_count();
        if (byte_cnt >= 16) begin
          emit(EvCid, {2'b00, CmdSendCid}, 8'd0, cmd_s0, es); byte_cnt = 0; ph = PhR1;
        end
      end
      PhSkip: ph = PhR1;
      PhR1: if (miso != IdleByte) begin
        emit(EvR1, ClsR1, miso, ss, es);
        ph = rd_pend ? PhRd : (wr_pend ? PhWr : PhIdle);
        if (app_pfx && tok[0][5:0] != CmdAppCmd) app_pfx = 0;
      end
      PhRd: if (rd_start) begin
        if (byte_cnt == 0) start_block(ss);
        bump_count();
        if (byte_cnt == blk_len) emit(EvRdData, {2'b00, CmdRead}, 8'd0, data_s0, es);
        else if (byte_cnt == blk_len + 13'd1) crc_s0 = ss;
        else if (byte_cnt == blk_len + 13'd2) begin
          emit(EvRdCrc, {2'b00, CmdRead}, 8'd0, crc_s0, es); ph = PhIdle;
        end
      end else if (miso == StartToken) begin
        emit(EvRdStart, {2'b00, CmdRead}, 8'd0, ss, es); rd_start = 1; byte_cnt = 0;
      end
      PhWr: if (wr_start) begin
        if (byte_cnt == 0) start_block(ss);
        bump_count();
        if (byte_cnt >= blk_len) begin
          emit(EvWrData, {2'b00, CmdWrite}, 8'd0, data_s0, es); byte_cnt = 0; ph = PhDresp;
        end
      end else if (mosi == StartToken) begin
        emit(EvWrStart, {2'b00, CmdWrite}, 8'd0, ss, es); wr_start = 1; byte_cnt = 0;
      end
      PhDresp: begin
        m = miso & 8'h1f;
        if ((m & 8'h11) == 8'h01) begin
          if (m == DrAccepted) emit(EvAccepted, ClsBit, m, ss, es);
          else if (m == DrCrcRej) emit(EvCrcRej, ClsBit, m, ss, es);
          else if (m == DrWrRej) emit(EvWrRej, ClsBit, m, ss, es);
          if (wr_pend) begin
            emit(EvDataResp, {2'b00, CmdWrite}, m, ss, es); ph = PhBusy; busy_first = 1;
          end else begin
            ph = PhIdle;
          end
        end
      end
      PhBusy: if (miso != 0) begin
        if (wr_pend) emit(EvBusy, {2'b00, CmdWrite}, 8'd0, busy_s0, busy_s1);
        ph = PhIdle;
      end else if (busy_first) begin
        busy_s0 = ss; busy_first = 0;
      end else begin
        busy_s1 = es;
      end
      default: ph = PhIdle;
    endcase
    if (step_q.size() > 0) step_q[$].last = 1'b1;
    foreach (step_q[i]) event_q.push_back(step_q[i]);
  endtask

  always @(posedge clk_i) begin
    res_t exp_r, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.event_kind = m_axis_tuser;
      {got.span_end, got.span_start, got.status_byte, got.token_crc, got.argument,
       got.app_command, got.command_index, got.ann_class} = m_axis_tdata[158:0];
      got.last = m_axis_tlast;
      if (event_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual %p", $realtime, got);
      end else begin
        exp_r = event_q.pop_front();
        if (got !== exp_r || m_axis_tdata[159] !== 1'b0) begin
          errors++;
          $display("%0t: mismatch, expected %p, actual %p", $realtime, exp_r, got);
        end
      end
    end
  end

  task automatic send_raw(logic md, logic mv, logic [7:0] mb, logic sv, logic [7:0] sb,
                          logic [47:0] ss, logic [47:0] es);
    int gap;
    gap = ($urandom_range(99) < tx_idle) ? $urandom_range(1, 4) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = md;
    s_axis_tdata = {6'd0, es, ss, sb, sv, mb, mv};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
    predict_events(s_axis_tdata, md);
  endtask

  task automatic send_pair(logic [7:0] mb, logic [7:0] sb);
    logic [47:0] ss;
    ss = sample_pos;
    sample_pos = sample_pos + 48'd16;
    send_raw(1'b0, 1'b1, mb, 1'b1, sb, ss, ss + 48'd15);
  endtask

  task automatic chip_select();
    send_raw(1'b1, 1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)), 8'($urandom),
             48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
  endtask

  task automatic send_cmd(logic [5:0] idx, logic [31:0] arg, logic [7:0] r1);
    send_pair({2'b01, idx}, $urandom_range(1) ? IdleByte : 8'($urandom));
    for (int i = 3; i >= 0; i--) send_pair(arg[i*8 +: 8], IdleByte);
    send_pair(8'($urandom) | 8'h01, IdleByte);
    send_pair(IdleByte, IdleByte);
    send_pair(IdleByte, r1);
  endtask

  function automatic int cur_len();
    return (blk_len == 0) ? 512 : blk_len;
  endfunction

  task automatic read_block();
    repeat ($urandom_range(0, 2)) send_pair(IdleByte, IdleByte);
    send_pair(IdleByte, StartToken);
    repeat (cur_len() + 2) send_pair(IdleByte, 8'($urandom));
  endtask

  task automatic send_wr_block(logic [7:0] resp);
    repeat ($urandom_range(0, 2)) send_pair(IdleByte, IdleByte);
    send_pair(StartToken, IdleByte);
    repeat (cur_len()) send_pair(8'($urandom), IdleByte);
    send_pair(IdleByte, resp);
    repeat ($urandom_range(1, 4)) send_pair(IdleByte, 8'd0);
    send_pair(IdleByte, IdleByte);
  endtask

  task automatic test_commands();
    send_pair(IdleByte, IdleByte);
    send_cmd(CmdGoIdle, 32'd0, 8'h01);
    send_cmd(CmdOpCond, 32'hffff_ffff, 8'h00);
    send_cmd(CmdCrcOnOff, 32'h0000_0001, 8'h00);
    send_cmd(CmdAppCmd, 32'd0, 8'h01);
    send_cmd(6'd41, 32'h4000_0000, 8'h00);
    send_cmd(6'd63, 32'h8000_0000, 8'h80);
    send_cmd(CmdSilent, 32'h1234_5678, 8'h00);
    send_raw(1'b0, 1'b0, 8'h55, 1'b0, 8'h55, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff);
  endtask

  task automatic test_csd_cid();
    chip_select();
    send_cmd(CmdSendCsd, 32'd0, 8'h00);
    repeat (19) send_pair(IdleByte, 8'($urandom));
    send_cmd(CmdSendCid, 32'd0, 8'h00);
    repeat (16) send_pair(IdleByte, 8'($urandom));
    send_pair(IdleByte, 8'h00);
  endtask

  task automatic test_read_block();
    chip_select();
    send_cmd(CmdBlockLen, 32'd1, 8'h00);
    send_cmd(CmdRead, 32'd0, 8'h00);
    read_block();
    send_cmd(CmdGoIdle, 32'd0, 8'h00);
    repeat (4) send_pair(IdleByte, 8'($urandom));
  endtask

  task automatic test_write_block();
    logic [7:0] codes [5] = '{8'he5, 8'heb, 8'hed, 8'he9, 8'h02};
    chip_select();
    send_cmd(CmdBlockLen, 32'd2, 8'h00);
    foreach (codes[i]) begin
      chip_select();
      send_cmd(CmdWrite, 32'd0, 8'h00);
      send_wr_block(codes[i]);
    end
  endtask

  task automatic test_block_length_extremes();
    chip_select();
    send_cmd(CmdBlockLen, 32'hffff_ffff, 8'h00);
    send_cmd(CmdRead, 32'd0, 8'h00);
    send_pair(IdleByte, StartToken);
    repeat (6) send_pair(IdleByte, 8'($urandom));
    chip_select();
    send_cmd(CmdBlockLen, 32'd0, 8'h00);
    send_cmd(CmdWrite, 32'd0, 8'h00);
    send_wr_block(8'h05);
    chip_select();
    send_cmd(CmdBlockLen, 32'd4, 8'h00);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    chip_select();
    repeat (8) send_cmd(CmdAppCmd, $urandom, 8'h01);
  endtask

  task automatic test_random(int tx_pct, int rx_pct, int n_items);
    int base;
    int sel;
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    base = sent_items;
    while (sent_items - base < n_items) begin
      sel = $urandom_range(99);
      if ($urandom_range(9) < 3) chip_select();
      if (sel < 15) begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(9) == 0) chip_select();
          else send_raw(1'b0, 1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)),
                        8'($urandom), 48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
        end
        chip_select();
        send_cmd(CmdBlockLen, $urandom_range(1, 8), 8'h00);
      end else if (sel < 30) begin
        send_cmd(CmdBlockLen, $urandom_range(1, 8), 8'($urandom_range(0, 254)));
      end else if (sel < 45) begin
        send_cmd(CmdRead, $urandom, 8'h00);
        read_block();
      end else if (sel < 60) begin
        send_cmd(CmdWrite, $urandom, 8'h00);
        send_wr_block(8'($urandom));
      end else if (sel < 68) begin
        send_cmd(CmdSendCsd, $urandom, 8'h00);
        repeat ($urandom_range(17, 21)) send_pair(8'($urandom), 8'($urandom));
      end else if (sel < 76) begin
        send_cmd(CmdSendCid, $urandom, 8'h00);
        repeat ($urandom_range(14, 18)) send_pair(8'($urandom), 8'($urandom));
      end else if (sel < 86) begin
        send_cmd(CmdAppCmd, $urandom, 8'h01);
        send_cmd(6'($urandom), $urandom, 8'($urandom_range(0, 254)));
      end else begin
        send_cmd(6'($urandom), $urandom, 8'($urandom));
        repeat ($urandom_range(0, 3)) send_pair(8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    int wait_cyc;
    ph = PhIdle; tok_cnt = 0; app_pfx = 0; rd_pend = 0; wr_pend = 0;
    rd_start = 0; wr_start = 0; busy_first = 0; byte_cnt = 0; blk_len = 0;
    cmd_s0 = 0; data_s0 = 0; crc_s0 = 0; busy_s0 = 0; busy_s1 = 0;
    foreach (tok[i]) tok[i] = 8'd0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    tx_idle = 19;
    rx_idle = 67;
    test_commands();
    test_csd_cid();
    test_read_block();
    test_write_block();
    test_block_length_extremes();
    test_backpressure();
    test_random(19, 67, 70);
    test_random(67, 19, 70);
    test_random(0, 0, 70);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (event_q.size() > 0) @(posedge clk_i);
    wait_cyc = 0;
    while (wait_cyc < 20) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    if (errors == 0 && event_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sdspi_pkg.sv
hw/rtl/sdspi_decode.sv
hw/rtl/sdspi_queue.sv
hw/rtl/sd_spi_protocol_decoder.sv
dv/tb_top.sv
